// ===== design/kms_pkg.sv =====
package kms_pkg;

    localparam int PORT_WIDTH = 16;
    localparam int ROW_STRIDE = 5;
    localparam int PIN_W      = $clog2(PORT_WIDTH);
    localparam int KEY_W      = 8;
    localparam int OFFSET_W   = 8;
    localparam int ROW_W      = 4;
    localparam int CODE_W     = 10;
    localparam int CFG_IDX_W  = 3;

    localparam logic [PORT_WIDTH-1:0] RELEASE_WORD = '1;
    localparam logic [KEY_W-1:0]      KEY_MAX      = '1;

    localparam logic [PORT_WIDTH-1:0] DRIVE_A_RESET = 16'h00F8;
    localparam logic [PORT_WIDTH-1:0] SENSE_A_RESET = 16'h7F07;
    localparam logic [PORT_WIDTH-1:0] DRIVE_B_RESET = 16'h1F00;
    localparam logic [PORT_WIDTH-1:0] SENSE_B_RESET = 16'h6007;
    localparam logic [OFFSET_W-1:0]   OFFSET_B_RESET = 8'd25;

    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSE_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENSE_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 3'd4;

    typedef enum logic [1:0] {
        ST_SCAN    = 2'd0,
        ST_DONE    = 2'd1,
        ST_BUSERR  = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    typedef struct packed {
        logic                  command;
        logic [PORT_WIDTH-1:0] sample_bits;
        logic                  bus_error;
    } in_beat_t;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] direction_mask;
        status_t               status;
        logic [KEY_W-1:0]      key_code;
    } out_beat_t;

    typedef struct packed {
        logic [PORT_WIDTH-1:0] drive_a;
        logic [PORT_WIDTH-1:0] sense_a;
        logic [PORT_WIDTH-1:0] drive_b;
        logic [PORT_WIDTH-1:0] sense_b;
        logic [OFFSET_W-1:0]   offset_b;
    } cfg_t;

    typedef struct packed {
        logic             scanning;
        logic             group_index;
        logic [PIN_W-1:0] drive_pin;
        logic [KEY_W-1:0] found_key;
    } scan_state_t;

    typedef struct packed {
        logic             hit;
        logic [PIN_W-1:0] idx;
    } pin_hit_t;

    function automatic pin_hit_t lowest_set(input logic [PORT_WIDTH-1:0] mask);
        pin_hit_t r;
        r.hit = 1'b0;
        r.idx = '0;
        for (int i = PORT_WIDTH - 1; i >= 0; i--) begin
            if (mask[i]) begin
                r.hit = 1'b1;
                r.idx = PIN_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [ROW_W-1:0] row_of(input logic [PIN_W-1:0] line);
        logic [ROW_W-1:0] r;
        case (line)
            4'd0:    r = 4'd7;
            4'd1:    r = 4'd6;
            4'd2:    r = 4'd5;
            4'd3:    r = 4'd4;
            4'd4:    r = 4'd3;
            4'd5:    r = 4'd2;
            4'd6:    r = 4'd1;
            4'd7:    r = 4'd0;
            4'd8:    r = 4'd0;
            4'd9:    r = 4'd1;
            4'd10:   r = 4'd2;
            4'd11:   r = 4'd3;
            4'd12:   r = 4'd4;
            4'd13:   r = 4'd8;
            4'd14:   r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/kms_step.sv =====
module kms_step (
    input  kms_pkg::cfg_t        cfg,
    input  kms_pkg::scan_state_t state,
    input  kms_pkg::in_beat_t    beat,
    output kms_pkg::scan_state_t state_next,
    output kms_pkg::out_beat_t   result
);

    logic [kms_pkg::PORT_WIDTH-1:0] drive_g;
    logic [kms_pkg::PORT_WIDTH-1:0] sense_g;
    logic [kms_pkg::PORT_WIDTH-1:0] pin_bit;
    logic [kms_pkg::PORT_WIDTH-1:0] above_mask;
    logic [kms_pkg::PORT_WIDTH-1:0] pressed;
    logic                           multi;
    logic [kms_pkg::OFFSET_W-1:0]   off;
    logic [kms_pkg::CODE_W-1:0]     code;
    logic [kms_pkg::KEY_W-1:0]      code_sat;
    logic [kms_pkg::KEY_W-1:0]      key_new;
    kms_pkg::pin_hit_t              hit_a;
    kms_pkg::pin_hit_t              hit_b;
    kms_pkg::pin_hit_t              hit_up;
    kms_pkg::pin_hit_t              hit_next;
    kms_pkg::pin_hit_t              first;
    logic                           next_group;

    always_comb begin
        drive_g    = state.group_index ? cfg.drive_b : cfg.drive_a;
        sense_g    = state.group_index ? cfg.sense_b : cfg.sense_a;
        off        = state.group_index ? cfg.offset_b : '0;
        pin_bit    = kms_pkg::PORT_WIDTH'(1) << state.drive_pin;
        above_mask = ~((pin_bit - kms_pkg::PORT_WIDTH'(1)) | pin_bit);
        pressed    = sense_g & ~beat.sample_bits;
        multi      = (pressed & (pressed - kms_pkg::PORT_WIDTH'(1))) != '0;
        hit_a      = kms_pkg::lowest_set(cfg.drive_a);
        hit_b      = kms_pkg::lowest_set(cfg.drive_b);
        hit_up     = kms_pkg::lowest_set(drive_g & above_mask);
        first      = kms_pkg::lowest_set(pressed);
        code       = kms_pkg::CODE_W'(off)
                   + kms_pkg::CODE_W'(kms_pkg::ROW_STRIDE)
                     * kms_pkg::CODE_W'(kms_pkg::row_of(first.idx))
                   + kms_pkg::CODE_W'(kms_pkg::row_of(state.drive_pin))
                   + kms_pkg::CODE_W'(1);
        code_sat   = (code > kms_pkg::CODE_W'(kms_pkg::KEY_MAX))
                   ? kms_pkg::KEY_MAX : code[kms_pkg::KEY_W-1:0];
        key_new    = first.hit ? code_sat : state.found_key;
        if (hit_up.hit) begin
            hit_next   = hit_up;
            next_group = state.group_index;
        end else if (!state.group_index) begin
            hit_next   = hit_b;
            next_group = 1'b1;
        end else begin
            hit_next   = hit_up;
            next_group = state.group_index;
        end
    end

    always_comb begin
        state_next = state;
        result.direction_mask = kms_pkg::RELEASE_WORD;
        result.status         = kms_pkg::ST_IGNORED;
        result.key_code       = '0;
        if (beat.command == kms_pkg::CMD_START) begin
            state_next.group_index = 1'b0;
            state_next.drive_pin   = '0;
            state_next.found_key   = '0;
            state_next.scanning    = 1'b0;
            if (beat.bus_error) begin
                result.status = kms_pkg::ST_BUSERR;
            end else if (hit_a.hit || hit_b.hit) begin
                state_next.scanning    = 1'b1;
                state_next.group_index = !hit_a.hit;
                state_next.drive_pin   = hit_a.hit ? hit_a.idx : hit_b.idx;
                result.direction_mask  = ~(kms_pkg::PORT_WIDTH'(1)
                                         << (hit_a.hit ? hit_a.idx : hit_b.idx));
                result.status          = kms_pkg::ST_SCAN;
            end else begin
                result.status = kms_pkg::ST_DONE;
            end
        end else if (!state.scanning) begin
            result.status = kms_pkg::ST_IGNORED;
        end else if (beat.bus_error) begin
            state_next.scanning = 1'b0;
            result.status       = kms_pkg::ST_BUSERR;
        end else if (first.hit && (state.found_key != '0 || multi)) begin
            state_next.scanning = 1'b0;
            if (state.found_key == '0) begin
                state_next.found_key = code_sat;
            end
            result.status = kms_pkg::ST_DONE;
        end else begin
            state_next.found_key = key_new;
            if (hit_next.hit) begin
                state_next.group_index = next_group;
                state_next.drive_pin   = hit_next.idx;
                result.direction_mask  = ~(kms_pkg::PORT_WIDTH'(1) << hit_next.idx);
                result.status          = kms_pkg::ST_SCAN;
            end else begin
                state_next.scanning = 1'b0;
                result.status       = kms_pkg::ST_DONE;
                result.key_code     = key_new;
            end
        end
    end

endmodule

// ===== design/key_matrix_scanner_top.sv =====
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_data  (command, sample_bits, bus_error)
// m_        out        m_valid / m_ready  m_data  (direction_mask, status, key_code)
// cfg_      in         cfg_we             cfg_addr, cfg_wdata
// One beat per cycle sustained while m_ready is high; a result passes through the
// input register, then result register. The scan state updates as a beat leaves
// the input register. Reset (aresetn low, synchronous) restores the register
// defaults and leaves the scanner idle. A stalled m_ready holds the result and,
// once the input register is also full, drops s_ready.
module key_matrix_scanner_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kms_pkg::in_beat_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kms_pkg::out_beat_t              m_data,
    input  logic                            cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [kms_pkg::PORT_WIDTH-1:0]  cfg_wdata
);

    kms_pkg::cfg_t        cfg_reg;
    kms_pkg::scan_state_t state_reg;
    kms_pkg::scan_state_t state_next;
    kms_pkg::in_beat_t    in_reg;
    logic                 in_valid_reg;
    kms_pkg::out_beat_t   out_reg;
    kms_pkg::out_beat_t   out_next;
    logic                 out_valid_reg;
    logic                 out_load;
    logic                 in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || out_load;
    assign in_load  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;

    kms_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .beat       (in_reg),
        .state_next (state_next),
        .result     (out_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_a  <= kms_pkg::DRIVE_A_RESET;
            cfg_reg.sense_a  <= kms_pkg::SENSE_A_RESET;
            cfg_reg.drive_b  <= kms_pkg::DRIVE_B_RESET;
            cfg_reg.sense_b  <= kms_pkg::SENSE_B_RESET;
            cfg_reg.offset_b <= kms_pkg::OFFSET_B_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                kms_pkg::REG_DRIVE_A:  cfg_reg.drive_a  <= cfg_wdata;
                kms_pkg::REG_SENSE_A:  cfg_reg.sense_a  <= cfg_wdata;
                kms_pkg::REG_DRIVE_B:  cfg_reg.drive_b  <= cfg_wdata;
                kms_pkg::REG_SENSE_B:  cfg_reg.sense_b  <= cfg_wdata;
                kms_pkg::REG_OFFSET_B: cfg_reg.offset_b <= cfg_wdata[kms_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                state_reg <= state_next;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_reg <= s_data;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    a_scan_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status == kms_pkg::ST_SCAN) |-> $onehot(~m_data.direction_mask))
        else $error("scan beat does not drive exactly one line");

    a_release_on_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != kms_pkg::ST_SCAN)
        |-> m_data.direction_mask == kms_pkg::RELEASE_WORD)
        else $error("ending beat does not release all lines");

    a_key_only_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != kms_pkg::ST_DONE) |-> m_data.key_code == '0)
        else $error("key code outside a done beat");

    a_idle_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_next.status != kms_pkg::ST_SCAN) |=> !state_reg.scanning)
        else $error("scanner still active after an ending beat");

endmodule

// ===== sim/key_matrix_scanner_top_tb.sv =====
module key_matrix_scanner_top_tb;

    localparam logic [63:0] LINE_ROW = 64'h0984_3210_0123_4567;
    localparam int PHASES    = 7;
    localparam int PER_PHASE = 175;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    kms_pkg::in_beat_t              s_data = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    kms_pkg::out_beat_t             m_data;
    logic                           cfg_we = 1'b0;
    logic [kms_pkg::CFG_IDX_W-1:0]  cfg_addr = kms_pkg::REG_DRIVE_A;
    logic [kms_pkg::PORT_WIDTH-1:0] cfg_wdata = '0;

    key_matrix_scanner_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    kms_pkg::cfg_t cfg_model = {kms_pkg::DRIVE_A_RESET, kms_pkg::SENSE_A_RESET,
                                kms_pkg::DRIVE_B_RESET, kms_pkg::SENSE_B_RESET,
                                kms_pkg::OFFSET_B_RESET};
    logic       scan_busy = 1'b0;
    int         scan_grp  = 0;
    int         scan_pin  = 0;
    logic [7:0] key_held  = '0;

    kms_pkg::in_beat_t  scan_beats[$];
    kms_pkg::out_beat_t due_results[$];
    kms_pkg::out_beat_t want;
    logic      idle_on = 1'b1;
    int        gap_left = 0;
    int        stall_left = 0;
    int        queued = 0;
    int        beats_sent = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        settings_used = 1;

    function automatic bit next_drive_line(input int grp, input int from);
        logic [15:0] m;
        for (int g = grp; g < 2; g++) begin
            m = g ? cfg_model.drive_b : cfg_model.drive_a;
            for (int p = (g == grp) ? from : 0; p < 16; p++) begin
                if (m[p]) begin
                    scan_grp = g;
                    scan_pin = p;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic kms_pkg::out_beat_t scan_step(input kms_pkg::in_beat_t b);
        kms_pkg::out_beat_t r;
        logic [15:0]        pressed;
        int                 code;
        r.direction_mask = kms_pkg::RELEASE_WORD;
        r.status = kms_pkg::ST_DONE;
        r.key_code = '0;
        if (b.command == kms_pkg::CMD_START) begin
            scan_grp = 0;
            scan_pin = 0;
            key_held = '0;
            scan_busy = 1'b0;
            if (b.bus_error) begin
                r.status = kms_pkg::ST_BUSERR;
                return r;
            end
            if (!next_drive_line(0, 0))
                return r;
            scan_busy = 1'b1;
            r.direction_mask = ~(16'h0001 << scan_pin);
            r.status = kms_pkg::ST_SCAN;
            return r;
        end
        if (!scan_busy) begin
            r.status = kms_pkg::ST_IGNORED;
            return r;
        end
        if (b.bus_error) begin
            scan_busy = 1'b0;
            r.status = kms_pkg::ST_BUSERR;
            return r;
        end
        pressed = (scan_grp ? cfg_model.sense_b : cfg_model.sense_a) & ~b.sample_bits;
        for (int i = 0; i < 16; i++) begin
            if (pressed[i]) begin
                if (key_held != 0) begin
                    scan_busy = 1'b0;
                    return r;
                end
                code = (scan_grp ? int'(cfg_model.offset_b) : 0)
                     + kms_pkg::ROW_STRIDE * int'(LINE_ROW[4*i +: 4])
                     + int'(LINE_ROW[4*scan_pin +: 4]) + 1;
                key_held = (code > 255) ? 8'hFF : code[7:0];
            end
        end
        if (!next_drive_line(scan_grp, scan_pin + 1)) begin
            scan_busy = 1'b0;
            r.key_code = key_held;
            return r;
        end
        r.direction_mask = ~(16'h0001 << scan_pin);
        r.status = kms_pkg::ST_SCAN;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_valid && s_ready) begin
                due_results.push_back(scan_step(s_data));
                beats_sent++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 4) == 0) begin
                    gap_left <= $urandom_range(0, 12);
                    s_valid <= 1'b0;
                end else if (scan_beats.size() > 0) begin
                    s_data <= scan_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result dir=%h st=%0d key=%0d", $time,
                             m_data.direction_mask, m_data.status, m_data.key_code);
                end else begin
                    want = due_results.pop_front();
                    if (m_data.direction_mask !== want.direction_mask ||
                        m_data.status !== want.status ||
                        m_data.key_code !== want.key_code) begin
                        mismatches++;
                        $display("%0t: expected dir=%h st=%0d key=%0d, got dir=%h st=%0d key=%0d",
                                 $time, want.direction_mask, want.status, want.key_code,
                                 m_data.direction_mask, m_data.status, m_data.key_code);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(0, 12);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_beat(input logic cmd, input logic [15:0] bits, input logic err);
        kms_pkg::in_beat_t b;
        b.command = cmd;
        b.sample_bits = bits;
        b.bus_error = err;
        scan_beats.push_back(b);
        queued++;
    endtask

    // start, then one sample per drive line; now and then a press, an error or a cut-off
    task automatic queue_scan();
        int          n_lines;
        logic [15:0] bits;
        n_lines = $countones(cfg_model.drive_a) + $countones(cfg_model.drive_b);
        push_beat(kms_pkg::CMD_START, 16'($urandom), $urandom_range(0, 39) == 0);
        for (int i = 0; i < n_lines; i++) begin
            if ($urandom_range(0, 49) == 0)
                break;
            case ($urandom_range(0, 19))
                0:       bits = 16'($urandom);
                1, 2:    bits = ~(16'h0001 << $urandom_range(0, 15))
                              & ~(16'h0001 << $urandom_range(0, 15));
                3, 4, 5: bits = ~(16'h0001 << $urandom_range(0, 15));
                default: bits = 16'hFFFF;
            endcase
            push_beat(kms_pkg::CMD_SAMPLE, bits, $urandom_range(0, 59) == 0);
        end
    endtask

    task automatic write_reg(input logic [kms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            kms_pkg::REG_DRIVE_A:  cfg_model.drive_a = val;
            kms_pkg::REG_SENSE_A:  cfg_model.sense_a = val;
            kms_pkg::REG_DRIVE_B:  cfg_model.drive_b = val;
            kms_pkg::REG_SENSE_B:  cfg_model.sense_b = val;
            kms_pkg::REG_OFFSET_B: cfg_model.offset_b = val[7:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        do
            @(negedge aclk);
        while (scan_beats.size() != 0 || s_valid || due_results.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        kms_pkg::cfg_t phase_cfg;
        int            target;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        push_beat(kms_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0);
        push_beat(kms_pkg::CMD_SAMPLE, 16'h0000, 1'b1);
        push_beat(kms_pkg::CMD_START,  16'hFFFF, 1'b1);
        push_beat(kms_pkg::CMD_START,  16'h0000, 1'b0);
        for (int i = 0; i < 10; i++)
            push_beat(kms_pkg::CMD_SAMPLE, (i == 6) ? 16'hBFFF : 16'hFFFF, 1'b0);
        push_beat(kms_pkg::CMD_START,  16'hFFFF, 1'b0);
        push_beat(kms_pkg::CMD_SAMPLE, 16'h0000, 1'b0);
        push_beat(kms_pkg::CMD_START,  16'hFFFF, 1'b0);
        push_beat(kms_pkg::CMD_SAMPLE, 16'hFFFF, 1'b0);
        push_beat(kms_pkg::CMD_START,  16'h5A5A, 1'b0);
        push_beat(kms_pkg::CMD_SAMPLE, 16'h0000, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                drain();
                case (ph)
                    1: phase_cfg = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd160};
                    2: phase_cfg = {16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd0};
                    3: phase_cfg = {16'($urandom), 16'($urandom), 16'h0000, 16'($urandom),
                                    8'($urandom_range(0, 160))};
                    4: phase_cfg = {16'h0000, 16'($urandom), 16'($urandom), 16'($urandom),
                                    8'($urandom_range(0, 160))};
                    default: phase_cfg = {16'($urandom & $urandom), 16'($urandom),
                                          16'($urandom & $urandom), 16'($urandom),
                                          8'($urandom_range(0, 160))};
                endcase
                write_reg(kms_pkg::REG_DRIVE_A, phase_cfg.drive_a);
                write_reg(kms_pkg::REG_SENSE_A, phase_cfg.sense_a);
                write_reg(kms_pkg::REG_DRIVE_B, phase_cfg.drive_b);
                write_reg(kms_pkg::REG_SENSE_B, phase_cfg.sense_b);
                write_reg(kms_pkg::REG_OFFSET_B, {8'h00, phase_cfg.offset_b});
                @(posedge aclk);
                cfg_we <= 1'b0;
                settings_used++;
                if (ph == PHASES - 1)
                    idle_on = 1'b0;
                @(negedge aclk);
            end
            target = queued + PER_PHASE;
            while (queued < target) begin
                if ($urandom_range(0, 7) == 0)
                    push_beat(1'($urandom), 16'($urandom), $urandom_range(0, 3) == 0);
                else
                    queue_scan();
            end
            if (ph < PHASES - 1) begin
                // leave a scan open across the next register change where the drive masks hold two or more lines
                push_beat(kms_pkg::CMD_START,  16'hFFFF, 1'b0);
                push_beat(kms_pkg::CMD_SAMPLE, 16'hFFFD, 1'b0);
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("Scanned %0d beats under %0d register settings, %0d results checked.",
                 beats_sent, settings_used, results_seen);
        $display("Covered idle samples, restarts, bus errors, double presses and empty masks.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still due", $time, due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
